[src/powerpc_load_store_unit_core_macros.svh]
// Assertion helpers for the checker file.
`ifndef POWERPC_LOAD_STORE_UNIT_CORE_MACROS_SVH
`define POWERPC_LOAD_STORE_UNIT_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PLSU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plsu check failed");

// Implication into the following cycle.
`define PLSU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plsu check failed");

`endif

[src/plsu_pkg.sv]
package plsu_pkg;

   localparam logic [5:0] OP_LBZ      = 6'd0;
   localparam logic [5:0] OP_LWZUX    = 6'd15;
   localparam logic [5:0] OP_LHBRX    = 6'd16;
   localparam logic [5:0] OP_LWBRX    = 6'd17;
   localparam logic [5:0] OP_LWARX    = 6'd18;
   localparam logic [5:0] OP_LMW      = 6'd19;
   localparam logic [5:0] OP_STB      = 6'd20;
   localparam logic [5:0] OP_STWUX    = 6'd31;
   localparam logic [5:0] OP_STHBRX   = 6'd32;
   localparam logic [5:0] OP_STWBRX   = 6'd33;
   localparam logic [5:0] OP_STMW     = 6'd34;
   localparam logic [5:0] OP_LFS      = 6'd35;
   localparam logic [5:0] OP_STFDUX   = 6'd50;
   localparam logic [5:0] OP_HOST_GPR = 6'd51;
   localparam logic [5:0] OP_HOST_FPR = 6'd52;

   localparam logic [4:0] LAST_REG = 5'd31;

   typedef struct packed {
      logic       valid_op;
      logic       host;
      logic [2:0] nbytes_m1;
      logic       store;
      logic       upd;
      logic       idx;
      logic       sext;
      logic       le;
      logic       res;
      logic       fpr;
      logic       mult;
   } ctl_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [4:0]  reg_a;
      logic [4:0]  reg_b;
      logic [4:0]  reg_d;
      logic [15:0] disp;
      logic [63:0] host_value;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] effective_address;
      logic        reg_written;
      logic        reg_is_float;
      logic [4:0]  reg_number;
      logic [63:0] reg_value;
      logic        mem_written;
      logic        reserve_valid;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BASE,
      ST_INDEX,
      ST_ISSUE,
      ST_SRC,
      ST_MEM,
      ST_MEMW,
      ST_WB,
      ST_UPD
   } state_type;

   function automatic ctl_type decode(input logic [5:0] op);
      ctl_type    c;
      logic [5:0] off;
      c = '0;
      off = op - OP_LFS;
      c.valid_op = 1'b1;
      case (op) inside
         [OP_LBZ:OP_LWZUX]: begin
            c.upd = op[0];
            c.idx = op[1];
            case (op[3:2])
               2'd0: c.nbytes_m1 = 3'd0;
               2'd1: begin
                  c.nbytes_m1 = 3'd1;
                  c.sext = 1'b1;
               end
               2'd2: c.nbytes_m1 = 3'd1;
               default: c.nbytes_m1 = 3'd3;
            endcase
         end
         OP_LHBRX: begin
            c.nbytes_m1 = 3'd1;
            c.le = 1'b1;
            c.idx = 1'b1;
         end
         OP_LWBRX: begin
            c.nbytes_m1 = 3'd3;
            c.le = 1'b1;
            c.idx = 1'b1;
         end
         OP_LWARX: begin
            c.nbytes_m1 = 3'd3;
            c.res = 1'b1;
            c.idx = 1'b1;
         end
         OP_LMW: begin
            c.nbytes_m1 = 3'd3;
            c.mult = 1'b1;
         end
         [OP_STB:OP_STWUX]: begin
            c.store = 1'b1;
            c.upd = op[0];
            c.idx = op[1];
            case (op[3:2])
               2'd1: c.nbytes_m1 = 3'd0;
               2'd2: c.nbytes_m1 = 3'd1;
               default: c.nbytes_m1 = 3'd3;
            endcase
         end
         OP_STHBRX: begin
            c.store = 1'b1;
            c.nbytes_m1 = 3'd1;
            c.le = 1'b1;
            c.idx = 1'b1;
         end
         OP_STWBRX: begin
            c.store = 1'b1;
            c.nbytes_m1 = 3'd3;
            c.le = 1'b1;
            c.idx = 1'b1;
         end
         OP_STMW: begin
            c.store = 1'b1;
            c.nbytes_m1 = 3'd3;
            c.mult = 1'b1;
         end
         [OP_LFS:OP_STFDUX]: begin
            c.fpr = 1'b1;
            c.store = off[3];
            c.nbytes_m1 = off[2] ? 3'd7 : 3'd3;
            c.upd = off[0];
            c.idx = off[1];
         end
         OP_HOST_GPR: c.host = 1'b1;
         OP_HOST_FPR: begin
            c.host = 1'b1;
            c.fpr = 1'b1;
         end
         default: c.valid_op = 1'b0;
      endcase
      return c;
   endfunction

endpackage

[src/plsu_ram.sv]
module plsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/plsu_front.sv]
module plsu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [5:0]          req_opcode,
   input  logic [4:0]          req_reg_a,
   input  logic [4:0]          req_reg_b,
   input  logic [4:0]          req_reg_d,
   input  logic signed [15:0]  req_displacement,
   input  logic [63:0]         req_host_value,
   output logic                q_valid,
   output plsu_pkg::item_type  q_item,
   input  logic                q_pop
);

   plsu_pkg::item_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         cnt_ff, cnt_in;
   plsu_pkg::item_type new_item;
   logic               push;

   always_comb begin
      new_item.ctl        = plsu_pkg::decode(req_opcode);
      new_item.reg_a      = req_reg_a;
      new_item.reg_b      = req_reg_b;
      new_item.reg_d      = req_reg_d;
      new_item.disp       = req_displacement;
      new_item.host_value = req_host_value;
   end

   assign busy    = (cnt_ff == 2'd2);
   // Unused opcodes are taken and dropped here; they never reach the back end.
   assign push    = start && !busy && new_item.ctl.valid_op;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

[src/plsu_back.sv]
module plsu_back #(
   parameter int MEM_BYTES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  plsu_pkg::item_type q_item,
   output logic               q_pop,
   output plsu_pkg::rsp_type  rsp
);

   localparam int AW = $clog2(MEM_BYTES);

   plsu_pkg::state_type state_ff, state_in;
   plsu_pkg::item_type  item_ff, item_in;
   logic [31:0]         ea_ff, ea_in;
   logic [4:0]          cur_ff, cur_in;
   logic [63:0]         src_ff, src_in;
   logic [63:0]         acc_ff, acc_in;
   logic [2:0]          byte_ff, byte_in;
   logic [31:0]         gpr_vld_ff, gpr_vld_in;
   logic [31:0]         fpr_vld_ff, fpr_vld_in;
   logic                gpr_rv_ff, fpr_rv_ff;
   logic                reserve_ff, reserve_in;
   plsu_pkg::rsp_type   rsp_ff, rsp_in;

   logic [4:0]  gpr_raddr, gpr_waddr, fpr_waddr;
   logic        gpr_we, fpr_we, mem_we;
   logic [31:0] gpr_rdata, gpr_wdata, gpr_eff;
   logic [63:0] fpr_rdata, fpr_wdata, fpr_eff;
   logic [7:0]  mem_rdata, mem_wdata;
   logic [31:0] byte_addr;
   logic [AW-1:0] mem_addr;
   logic [2:0]  shift_bytes;
   logic [63:0] load_value;
   logic        last_byte;
   logic        last_word;

   plsu_ram #(.WIDTH(32), .DEPTH(32)) u_gpr (
      .clock(clock), .we(gpr_we), .waddr(gpr_waddr), .wdata(gpr_wdata),
      .raddr(gpr_raddr), .rdata(gpr_rdata)
   );

   plsu_ram #(.WIDTH(64), .DEPTH(32)) u_fpr (
      .clock(clock), .we(fpr_we), .waddr(fpr_waddr), .wdata(fpr_wdata),
      .raddr(cur_ff), .rdata(fpr_rdata)
   );

   plsu_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock(clock), .we(mem_we), .waddr(mem_addr), .wdata(mem_wdata),
      .raddr(mem_addr), .rdata(mem_rdata)
   );

   // Register entries never written since reset read as zero.
   assign gpr_eff = gpr_rv_ff ? gpr_rdata : 32'd0;
   assign fpr_eff = fpr_rv_ff ? fpr_rdata : 64'd0;

   always_comb begin
      case (state_ff)
         plsu_pkg::ST_IDLE:  gpr_raddr = q_item.reg_a;
         plsu_pkg::ST_BASE:  gpr_raddr = item_ff.reg_b;
         plsu_pkg::ST_ISSUE: gpr_raddr = cur_ff;
         default:            gpr_raddr = item_ff.reg_a;
      endcase
   end

   assign byte_addr   = ea_ff + {29'd0, byte_ff};
   assign mem_addr    = byte_addr[AW-1:0];
   assign last_byte   = (byte_ff == item_ff.ctl.nbytes_m1);
   assign last_word   = !item_ff.ctl.mult || (cur_ff == plsu_pkg::LAST_REG);
   assign shift_bytes = item_ff.ctl.le ? byte_ff : (item_ff.ctl.nbytes_m1 - byte_ff);
   assign mem_wdata   = 8'(src_ff >> {shift_bytes, 3'b000});

   always_comb begin
      if (item_ff.ctl.fpr) begin
         load_value = (item_ff.ctl.nbytes_m1 == 3'd3) ?
                      {acc_ff[31:0], acc_ff[31:0]} : acc_ff;
      end else if (item_ff.ctl.sext) begin
         load_value = {32'd0, {16{acc_ff[15]}}, acc_ff[15:0]};
      end else begin
         load_value = {32'd0, acc_ff[31:0]};
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         plsu_pkg::ST_IDLE: begin
            if (q_valid && !q_item.ctl.host) begin
               state_in = plsu_pkg::ST_BASE;
            end
         end
         plsu_pkg::ST_BASE:  state_in = plsu_pkg::ST_INDEX;
         plsu_pkg::ST_INDEX: state_in = plsu_pkg::ST_ISSUE;
         plsu_pkg::ST_ISSUE: state_in = plsu_pkg::ST_SRC;
         plsu_pkg::ST_SRC:   state_in = plsu_pkg::ST_MEM;
         plsu_pkg::ST_MEM: begin
            if (!item_ff.ctl.store) begin
               state_in = plsu_pkg::ST_MEMW;
            end else if (last_byte) begin
               state_in = plsu_pkg::ST_WB;
            end
         end
         plsu_pkg::ST_MEMW: begin
            state_in = last_byte ? plsu_pkg::ST_WB : plsu_pkg::ST_MEM;
         end
         plsu_pkg::ST_WB: begin
            if (!item_ff.ctl.store && item_ff.ctl.upd) begin
               state_in = plsu_pkg::ST_UPD;
            end else if (!last_word) begin
               state_in = plsu_pkg::ST_ISSUE;
            end else begin
               state_in = plsu_pkg::ST_IDLE;
            end
         end
         plsu_pkg::ST_UPD: state_in = plsu_pkg::ST_IDLE;
         default:          state_in = plsu_pkg::ST_IDLE;
      endcase
   end

   // Datapath, register file writes and results.
   always_comb begin
      item_in    = item_ff;
      ea_in      = ea_ff;
      cur_in     = cur_ff;
      src_in     = src_ff;
      acc_in     = acc_ff;
      byte_in    = byte_ff;
      reserve_in = reserve_ff;
      q_pop      = 1'b0;
      gpr_we     = 1'b0;
      gpr_waddr  = cur_ff;
      gpr_wdata  = load_value[31:0];
      fpr_we     = 1'b0;
      fpr_waddr  = cur_ff;
      fpr_wdata  = load_value;
      mem_we     = 1'b0;
      rsp_in     = '0;
      case (state_ff)
         plsu_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               cur_in  = q_item.reg_d;
               if (q_item.ctl.host) begin
                  gpr_waddr = q_item.reg_d;
                  fpr_waddr = q_item.reg_d;
                  gpr_wdata = q_item.host_value[31:0];
                  fpr_wdata = q_item.host_value;
                  gpr_we    = !q_item.ctl.fpr;
                  fpr_we    = q_item.ctl.fpr;
                  rsp_in.valid        = 1'b1;
                  rsp_in.reg_written  = 1'b1;
                  rsp_in.reg_is_float = q_item.ctl.fpr;
                  rsp_in.reg_number   = q_item.reg_d;
                  rsp_in.reg_value    = q_item.ctl.fpr ? q_item.host_value :
                                        {32'd0, q_item.host_value[31:0]};
                  rsp_in.reserve_valid = reserve_ff;
                  rsp_in.last         = 1'b1;
               end
            end
         end
         plsu_pkg::ST_BASE: begin
            ea_in = (!item_ff.ctl.upd && item_ff.reg_a == 5'd0) ? 32'd0 : gpr_eff;
         end
         plsu_pkg::ST_INDEX: begin
            ea_in = ea_ff + (item_ff.ctl.idx ? gpr_eff :
                             {{16{item_ff.disp[15]}}, item_ff.disp});
         end
         plsu_pkg::ST_SRC: begin
            if (!item_ff.ctl.fpr) begin
               src_in = {32'd0, gpr_eff};
            end else if (item_ff.ctl.nbytes_m1 == 3'd7) begin
               src_in = fpr_eff;
            end else begin
               src_in = {32'd0, fpr_eff[31:0]};
            end
            acc_in  = 64'd0;
            byte_in = 3'd0;
         end
         plsu_pkg::ST_MEM: begin
            if (item_ff.ctl.store) begin
               mem_we  = 1'b1;
               byte_in = byte_ff + 3'd1;
            end
         end
         plsu_pkg::ST_MEMW: begin
            if (item_ff.ctl.le) begin
               acc_in = acc_ff | ({56'd0, mem_rdata} << {byte_ff, 3'b000});
            end else begin
               acc_in = {acc_ff[55:0], mem_rdata};
            end
            byte_in = byte_ff + 3'd1;
         end
         plsu_pkg::ST_WB: begin
            rsp_in.valid             = 1'b1;
            rsp_in.effective_address = ea_ff;
            rsp_in.reserve_valid     = reserve_ff;
            if (item_ff.ctl.store) begin
               rsp_in.mem_written = 1'b1;
               rsp_in.last        = last_word;
               if (item_ff.ctl.upd) begin
                  gpr_we             = 1'b1;
                  gpr_waddr          = item_ff.reg_a;
                  gpr_wdata          = ea_ff;
                  rsp_in.reg_written = 1'b1;
                  rsp_in.reg_number  = item_ff.reg_a;
                  rsp_in.reg_value   = {32'd0, ea_ff};
               end
            end else begin
               gpr_we              = !item_ff.ctl.fpr;
               fpr_we              = item_ff.ctl.fpr;
               rsp_in.reg_written  = 1'b1;
               rsp_in.reg_is_float = item_ff.ctl.fpr;
               rsp_in.reg_number   = cur_ff;
               rsp_in.reg_value    = load_value;
               rsp_in.last         = last_word && !item_ff.ctl.upd;
               if (item_ff.ctl.res) begin
                  reserve_in           = 1'b1;
                  rsp_in.reserve_valid = 1'b1;
               end
            end
            if (!last_word) begin
               cur_in = cur_ff + 5'd1;
               ea_in  = ea_ff + 32'd4;
            end
         end
         plsu_pkg::ST_UPD: begin
            gpr_we                   = 1'b1;
            gpr_waddr                = item_ff.reg_a;
            gpr_wdata                = ea_ff;
            rsp_in.valid             = 1'b1;
            rsp_in.effective_address = ea_ff;
            rsp_in.reg_written       = 1'b1;
            rsp_in.reg_number        = item_ff.reg_a;
            rsp_in.reg_value         = {32'd0, ea_ff};
            rsp_in.reserve_valid     = reserve_ff;
            rsp_in.last              = 1'b1;
         end
         default: begin
         end
      endcase
      gpr_vld_in = gpr_vld_ff;
      fpr_vld_in = fpr_vld_ff;
      if (gpr_we) begin
         gpr_vld_in[gpr_waddr] = 1'b1;
      end
      if (fpr_we) begin
         fpr_vld_in[fpr_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      ea_ff   <= ea_in;
      cur_ff  <= cur_in;
      src_ff  <= src_in;
      acc_ff  <= acc_in;
      byte_ff <= byte_in;
      if (reset) begin
         state_ff   <= plsu_pkg::ST_IDLE;
         gpr_vld_ff <= '0;
         fpr_vld_ff <= '0;
         gpr_rv_ff  <= 1'b0;
         fpr_rv_ff  <= 1'b0;
         reserve_ff <= 1'b0;
         rsp_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         gpr_vld_ff <= gpr_vld_in;
         fpr_vld_ff <= fpr_vld_in;
         gpr_rv_ff  <= gpr_vld_ff[gpr_raddr];
         fpr_rv_ff  <= fpr_vld_ff[cur_ff];
         reserve_ff <= reserve_in;
         rsp_ff     <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

[src/powerpc_load_store_unit_core.sv]
// PowerPC load/store unit. Instructions are taken on start while busy is low
// and queue up to two deep; busy rises only when that queue is full. Each
// instruction then runs alone on one execution sequencer: ST_IDLE takes it
// from the queue; ST_BASE, ST_INDEX, ST_ISSUE and ST_SRC read the base, index
// and source registers from the single-read-port register files; each byte
// loaded is read in ST_MEM and captured in ST_MEMW, and each byte stored is
// written in ST_MEM, through the byte-wide data memory port; ST_WB gives each
// result. An update load adds ST_UPD, lmw/stmw repeat ST_ISSUE, ST_SRC, the
// byte steps and ST_WB for every word, and host register writes are done in
// ST_IDLE. Results come out one per cycle on rsp_valid and cannot be held off
// by the receiver. MEM_BYTES must be a power of two; addresses wrap within it.
module powerpc_load_store_unit_core #(
   parameter int MEM_BYTES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [5:0]         req_opcode,
   input  logic [4:0]         req_reg_a,
   input  logic [4:0]         req_reg_b,
   input  logic [4:0]         req_reg_d,
   input  logic signed [15:0] req_displacement,
   input  logic [63:0]        req_host_value,
   output logic               rsp_valid,
   output logic [31:0]        rsp_effective_address,
   output logic               rsp_reg_written,
   output logic               rsp_reg_is_float,
   output logic [4:0]         rsp_reg_number,
   output logic [63:0]        rsp_reg_value,
   output logic               rsp_mem_written,
   output logic               rsp_reserve_valid,
   output logic               rsp_last
);

   logic               q_valid;
   logic               q_pop;
   plsu_pkg::item_type q_item;
   plsu_pkg::rsp_type  rsp;

   plsu_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_reg_a(req_reg_a), .req_reg_b(req_reg_b),
      .req_reg_d(req_reg_d), .req_displacement(req_displacement),
      .req_host_value(req_host_value),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   plsu_back #(.MEM_BYTES(MEM_BYTES)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item),
      .q_pop(q_pop), .rsp(rsp)
   );

   assign rsp_valid             = rsp.valid;
   assign rsp_effective_address = rsp.effective_address;
   assign rsp_reg_written       = rsp.reg_written;
   assign rsp_reg_is_float      = rsp.reg_is_float;
   assign rsp_reg_number        = rsp.reg_number;
   assign rsp_reg_value         = rsp.reg_value;
   assign rsp_mem_written       = rsp.mem_written;
   assign rsp_reserve_valid     = rsp.reserve_valid;
   assign rsp_last              = rsp.last;

endmodule

[src/plsu_checker.sv]
`include "powerpc_load_store_unit_core_macros.svh"

module plsu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_reg_written,
   input logic        rsp_reg_is_float,
   input logic [4:0]  rsp_reg_number,
   input logic [63:0] rsp_reg_value,
   input logic        rsp_mem_written,
   input logic        rsp_reserve_valid
);

   // Fields that mean nothing without a register transfer are zero.
   `PLSU_ASSERT_NOW(a_no_reg_fields, clock, reset, rsp_valid && !rsp_reg_written, rsp_reg_number == 5'd0 && rsp_reg_value == 64'd0 && !rsp_reg_is_float)
   // Stores only ever write back a GPR (the update base).
   `PLSU_ASSERT_NOW(a_store_gpr, clock, reset, rsp_valid && rsp_mem_written, !rsp_reg_is_float)
   // A GPR transfer carries a zero-extended 32-bit value.
   `PLSU_ASSERT_NOW(a_gpr_width, clock, reset, rsp_valid && rsp_reg_written && !rsp_reg_is_float, rsp_reg_value[63:32] == 32'd0)
   // Nothing clears the reservation once set.
   `PLSU_ASSERT_NEXT(a_reserve_sticky, clock, reset, rsp_valid && rsp_reserve_valid, !rsp_valid || rsp_reserve_valid)

endmodule

bind powerpc_load_store_unit_core plsu_checker u_plsu_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_reg_written(rsp_reg_written),
   .rsp_reg_is_float(rsp_reg_is_float),
   .rsp_reg_number(rsp_reg_number),
   .rsp_reg_value(rsp_reg_value),
   .rsp_mem_written(rsp_mem_written),
   .rsp_reserve_valid(rsp_reserve_valid)
);

[test/testbench.sv]
module testbench;

   // Opcodes that the package does not name.
   localparam logic [5:0] OP_LHA   = 6'd4;
   localparam logic [5:0] OP_LHZ   = 6'd8;
   localparam logic [5:0] OP_LWZ   = 6'd12;
   localparam logic [5:0] OP_LWZU  = 6'd13;
   localparam logic [5:0] OP_STBUX = 6'd23;
   localparam logic [5:0] OP_STW   = 6'd28;
   localparam logic [5:0] OP_LFSX  = 6'd37;
   localparam logic [5:0] OP_LFDU  = 6'd40;
   localparam logic [5:0] OP_STFS  = 6'd43;
   localparam logic [5:0] OP_UNUSED_MAX = 6'd63;

   localparam int MEM_SIZE = 4096;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 345;

   typedef struct {
      logic [31:0] ea;
      logic        rw;
      logic        rf;
      logic [4:0]  rn;
      logic [63:0] rv;
      logic        mw;
      logic        rsv;
      logic        last;
   } access_result_type;

   typedef struct {
      logic [5:0]  op;
      logic [4:0]  ra;
      logic [4:0]  rb;
      logic [4:0]  rd;
      logic [15:0] disp;
      logic [63:0] hv;
      bit          typed;
      logic [31:0] t_ea;
      logic [63:0] t_val;
   } instr_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [5:0]         req_opcode;
   logic [4:0]         req_reg_a;
   logic [4:0]         req_reg_b;
   logic [4:0]         req_reg_d;
   logic signed [15:0] req_displacement;
   logic [63:0]        req_host_value;
   logic               rsp_valid;
   logic [31:0]        rsp_effective_address;
   logic               rsp_reg_written;
   logic               rsp_reg_is_float;
   logic [4:0]         rsp_reg_number;
   logic [63:0]        rsp_reg_value;
   logic               rsp_mem_written;
   logic               rsp_reserve_valid;
   logic               rsp_last;

   powerpc_load_store_unit_core #(.MEM_BYTES(MEM_SIZE)) DUT (.*);

   logic [31:0] gpr_shadow [32];
   logic [63:0] fpr_shadow [32];
   logic [7:0]  mem_shadow [MEM_SIZE];
   logic        reserve_shadow;
   access_result_type pending_results [$];
   bit failed;
   int idle_count;

   initial begin
      clock = 1'b0;
   end
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic push_result(input logic [31:0] ea, input logic rw, input logic rf,
                              input logic [4:0] rn, input logic [63:0] rv,
                              input logic mw, input logic last);
      access_result_type r;
      r.ea = ea;
      r.rw = rw;
      r.rf = rf;
      r.rn = rn;
      r.rv = rv;
      r.mw = mw;
      r.rsv = reserve_shadow;
      r.last = last;
      pending_results.push_back(r);
   endtask

   function automatic logic [63:0] load_bytes(input logic [31:0] ea, input int n,
                                              input bit le);
      logic [63:0] v;
      logic [63:0] b;
      v = '0;
      for (int i = 0; i < n; i++) begin
         b = 64'(mem_shadow[(ea + i) % MEM_SIZE]);
         if (le) v |= b << (8 * i);
         else v = (v << 8) | b;
      end
      return v;
   endfunction

   task automatic store_bytes(input logic [31:0] ea, input int n, input bit le,
                              input logic [63:0] v);
      int sh;
      for (int i = 0; i < n; i++) begin
         sh = le ? 8 * i : 8 * (n - 1 - i);
         mem_shadow[(ea + i) % MEM_SIZE] = v[sh +: 8];
      end
   endtask

   // Updates the shadow state and queues the results of one instruction.
   task automatic execute_access(input logic [5:0] op, input logic [4:0] ra,
                                 input logic [4:0] rb, input logic [4:0] rd,
                                 input logic [15:0] disp, input logic [63:0] hv);
      int size;
      bit st, upd, idx, sext, le, res, fp, mult;
      logic [5:0] off;
      logic [31:0] base;
      logic [31:0] ea;
      logic [31:0] wa;
      logic [63:0] v;
      size = 4;
      {st, upd, idx, sext, le, res, fp, mult} = '0;
      if (op == plsu_pkg::OP_HOST_GPR) begin
         gpr_shadow[rd] = hv[31:0];
         push_result(32'd0, 1'b1, 1'b0, rd, {32'd0, hv[31:0]}, 1'b0, 1'b1);
         return;
      end
      if (op == plsu_pkg::OP_HOST_FPR) begin
         fpr_shadow[rd] = hv;
         push_result(32'd0, 1'b1, 1'b1, rd, hv, 1'b0, 1'b1);
         return;
      end
      if (op > plsu_pkg::OP_STFDUX) return;
      if (op <= plsu_pkg::OP_LWZUX) begin
         upd = op[0];
         idx = op[1];
         sext = (op[3:2] == 2'd1);
         size = (op[3:2] == 2'd0) ? 1 : (op[3:2] == 2'd3) ? 4 : 2;
      end else if (op == plsu_pkg::OP_LHBRX || op == plsu_pkg::OP_STHBRX) begin
         size = 2;
         le = 1;
         idx = 1;
         st = (op == plsu_pkg::OP_STHBRX);
      end else if (op == plsu_pkg::OP_LWBRX || op == plsu_pkg::OP_STWBRX) begin
         le = 1;
         idx = 1;
         st = (op == plsu_pkg::OP_STWBRX);
      end else if (op == plsu_pkg::OP_LWARX) begin
         res = 1;
         idx = 1;
      end else if (op == plsu_pkg::OP_LMW || op == plsu_pkg::OP_STMW) begin
         mult = 1;
         st = (op == plsu_pkg::OP_STMW);
      end else if (op <= plsu_pkg::OP_STWUX) begin
         off = op - plsu_pkg::OP_STB;
         st = 1;
         upd = off[0];
         idx = off[1];
         size = (off[3:2] == 2'd0) ? 1 : (off[3:2] == 2'd1) ? 2 : 4;
      end else begin
         off = op - plsu_pkg::OP_LFS;
         fp = 1;
         st = off[3];
         size = off[2] ? 8 : 4;
         upd = off[0];
         idx = off[1];
      end

      base = (!upd && ra == 5'd0) ? 32'd0 : gpr_shadow[ra];
      ea = base + (idx ? gpr_shadow[rb] : {{16{disp[15]}}, disp});

      if (mult) begin
         for (int r = int'(rd); r <= int'(plsu_pkg::LAST_REG); r++) begin
            wa = ea + 32'(4 * (r - int'(rd)));
            if (st) begin
               store_bytes(wa, 4, 0, {32'd0, gpr_shadow[r]});
               push_result(wa, 1'b0, 1'b0, 5'd0, 64'd0, 1'b1,
                           r == int'(plsu_pkg::LAST_REG));
            end else begin
               v = load_bytes(wa, 4, 0);
               gpr_shadow[r] = v[31:0];
               push_result(wa, 1'b1, 1'b0, 5'(r), v, 1'b0,
                           r == int'(plsu_pkg::LAST_REG));
            end
         end
         return;
      end

      if (st) begin
         if (fp) v = (size == 8) ? fpr_shadow[rd] : {32'd0, fpr_shadow[rd][31:0]};
         else v = {32'd0, gpr_shadow[rd]};
         store_bytes(ea, size, le, v);
         if (upd) begin
            gpr_shadow[ra] = ea;
            push_result(ea, 1'b1, 1'b0, ra, {32'd0, ea}, 1'b1, 1'b1);
         end else begin
            push_result(ea, 1'b0, 1'b0, 5'd0, 64'd0, 1'b1, 1'b1);
         end
         return;
      end

      v = load_bytes(ea, size, le);
      if (fp) begin
         if (size == 4) v = {v[31:0], v[31:0]};
         fpr_shadow[rd] = v;
      end else begin
         if (sext && v[15]) v[31:16] = 16'hFFFF;
         v[63:32] = '0;
         gpr_shadow[rd] = v[31:0];
      end
      if (res) reserve_shadow = 1'b1;
      push_result(ea, 1'b1, fp, rd, v, 1'b0, !upd);
      if (upd) begin
         gpr_shadow[ra] = ea;
         push_result(ea, 1'b1, 1'b0, ra, {32'd0, ea}, 1'b0, 1'b1);
      end
   endtask

   // Holds the instruction on the request ports until the unit takes it.
   task automatic issue(input instr_row_type row);
      access_result_type first;
      int n;
      @(negedge clock);
      req_opcode = row.op;
      req_reg_a = row.ra;
      req_reg_b = row.rb;
      req_reg_d = row.rd;
      req_displacement = row.disp;
      req_host_value = row.hv;
      start = 1'b1;
      do @(posedge clock); while (busy);
      n = pending_results.size();
      execute_access(row.op, row.ra, row.rb, row.rd, row.disp, row.hv);
      if (row.typed) begin
         first = pending_results[n];
         first.ea = row.t_ea;
         first.rv = row.t_val;
         pending_results[n] = first;
      end
   endtask

   task automatic pause(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   function automatic instr_row_type make_row(input logic [5:0] op, input logic [4:0] ra,
                                             input logic [4:0] rb, input logic [4:0] rd,
                                             input logic [15:0] disp,
                                             input logic [63:0] hv);
      instr_row_type row;
      row.op = op;
      row.ra = ra;
      row.rb = rb;
      row.rd = rd;
      row.disp = disp;
      row.hv = hv;
      row.typed = 0;
      row.t_ea = '0;
      row.t_val = '0;
      return row;
   endfunction

   function automatic instr_row_type typed_row(input instr_row_type row,
                                              input logic [31:0] ea,
                                              input logic [63:0] val);
      row.typed = 1;
      row.t_ea = ea;
      row.t_val = val;
      return row;
   endfunction

   task automatic compare(input string name, input logic [63:0] exp_v,
                          input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         failed = 1;
      end
   endtask

   always @(posedge clock) begin
      access_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing expected");
            failed = 1;
         end else begin
            e = pending_results.pop_front();
            compare("effective_address", 64'(e.ea), 64'(rsp_effective_address));
            compare("reg_written", 64'(e.rw), 64'(rsp_reg_written));
            compare("reg_is_float", 64'(e.rf), 64'(rsp_reg_is_float));
            compare("reg_number", 64'(e.rn), 64'(rsp_reg_number));
            compare("reg_value", e.rv, rsp_reg_value);
            compare("mem_written", 64'(e.mw), 64'(rsp_mem_written));
            compare("reserve_valid", 64'(e.rsv), 64'(rsp_reserve_valid));
            compare("last", 64'(e.last), 64'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      instr_row_type rows [$];
      instr_row_type row;
      int counted;
      int pick;
      failed = 0;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = '0;
      req_reg_a = '0;
      req_reg_b = '0;
      req_reg_d = '0;
      req_displacement = '0;
      req_host_value = '0;
      for (int i = 0; i < 32; i++) begin
         gpr_shadow[i] = '0;
         fpr_shadow[i] = '0;
      end
      for (int i = 0; i < MEM_SIZE; i++) mem_shadow[i] = '0;
      reserve_shadow = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Fill every memory byte with stores of random registers first, so that
      // no later load can touch an unwritten location.
      for (int r = 0; r < 32; r++)
         issue(make_row(plsu_pkg::OP_HOST_GPR, 5'd0, 5'd0, 5'(r), 16'd0,
                        {$urandom, $urandom}));
      for (int k = 0; k < MEM_SIZE / 128; k++)
         issue(make_row(plsu_pkg::OP_STMW, 5'd0, 5'd0, 5'd0, 16'(128 * k), 64'd0));

      rows.push_back(typed_row(make_row(plsu_pkg::OP_HOST_GPR, 5'd0, 5'd0, 5'd1, 16'd0,
                                        '1), 32'd0, 64'hFFFF_FFFF));
      rows.push_back(typed_row(make_row(plsu_pkg::OP_HOST_FPR, 5'd0, 5'd0, 5'd2, 16'd0,
                                        '1), 32'd0, '1));
      rows.push_back(make_row(plsu_pkg::OP_HOST_GPR, 5'd0, 5'd0, 5'd3, 16'd0, 64'h0FF0));
      rows.push_back(make_row(plsu_pkg::OP_HOST_GPR, 5'd0, 5'd0, 5'd0, 16'd0, 64'h0100));
      rows.push_back(typed_row(make_row(OP_STW, 5'd0, 5'd0, 5'd1, 16'd0, 64'd0),
                               32'd0, 64'd0));
      rows.push_back(typed_row(make_row(OP_LHA, 5'd0, 5'd0, 5'd5, 16'd0, 64'd0),
                               32'd0, 64'hFFFF_FFFF));
      rows.push_back(typed_row(make_row(OP_LHZ, 5'd0, 5'd0, 5'd6, 16'd2, 64'd0),
                               32'd2, 64'hFFFF));
      rows.push_back(make_row(OP_LFSX, 5'd0, 5'd0, 5'd9, 16'd0, 64'd0));
      rows.push_back(make_row(plsu_pkg::OP_LBZ, 5'd0, 5'd0, 5'd7, 16'hFFFF, 64'd0));
      rows.push_back(make_row(plsu_pkg::OP_STB, 5'd3, 5'd0, 5'd1, 16'h7FFF, 64'd0));
      rows.push_back(make_row(OP_STBUX, 5'd0, 5'd3, 5'd1, 16'd0, 64'd0));
      rows.push_back(make_row(OP_LWZU, 5'd4, 5'd0, 5'd4, 16'd4, 64'd0));
      rows.push_back(make_row(plsu_pkg::OP_LHBRX, 5'd0, 5'd3, 5'd8, 16'd0, 64'd0));
      rows.push_back(make_row(plsu_pkg::OP_LWBRX, 5'd3, 5'd3, 5'd10, 16'd0, 64'd0));
      rows.push_back(make_row(plsu_pkg::OP_LWARX, 5'd0, 5'd3, 5'd11, 16'd0, 64'd0));
      rows.push_back(make_row(plsu_pkg::OP_STHBRX, 5'd0, 5'd3, 5'd1, 16'd0, 64'd0));
      rows.push_back(make_row(plsu_pkg::OP_STWBRX, 5'd1, 5'd3, 5'd3, 16'd0, 64'd0));
      rows.push_back(make_row(plsu_pkg::OP_STMW, 5'd0, 5'd0, 5'd31, 16'd16, 64'd0));
      rows.push_back(make_row(OP_LFDU, 5'd3, 5'd0, 5'd12, 16'h8000, 64'd0));
      rows.push_back(make_row(OP_STFS, 5'd0, 5'd0, 5'd2, 16'd64, 64'd0));
      rows.push_back(make_row(plsu_pkg::OP_STFDUX, 5'd5, 5'd3, 5'd2, 16'd0, 64'd0));
      rows.push_back(make_row(OP_LWZ, 5'd0, 5'd0, 5'd13, 16'd64, 64'd0));
      rows.push_back(make_row(OP_UNUSED_MAX, 5'd31, 5'd31, 5'd31, 16'hFFFF, '1));
      rows.push_back(make_row(plsu_pkg::OP_LMW, 5'd0, 5'd0, 5'd0, 16'h8000, 64'd0));
      rows.push_back(make_row(plsu_pkg::OP_LMW, 5'd28, 5'd0, 5'd28, 16'd0, 64'd0));
      foreach (rows[i]) issue(rows[i]);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         row = make_row(6'($urandom_range(0, plsu_pkg::OP_STFDUX)), 5'($urandom),
                        5'($urandom), 5'($urandom), 16'($urandom),
                        {$urandom, $urandom});
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            row.op = $urandom_range(0, 1) ? plsu_pkg::OP_HOST_GPR : plsu_pkg::OP_HOST_FPR;
         end else if (pick < 14) begin
            row.op = 6'($urandom_range(plsu_pkg::OP_HOST_FPR + 1, OP_UNUSED_MAX));
         end else if (pick < 22) begin
            // Mostly short multiple-word transfers, now and then a long one.
            row.op = $urandom_range(0, 1) ? plsu_pkg::OP_LMW : plsu_pkg::OP_STMW;
            if ($urandom_range(0, 3) != 0) row.rd = 5'($urandom_range(24, 31));
         end
         if (counted == RANDOM_ITEMS / 2) begin
            @(negedge clock);
            start = 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         if (counted < RANDOM_ITEMS - 60 && $urandom_range(0, 7) == 0)
            pause($urandom_range(1, 19));
         issue(row);
         if (row.op <= plsu_pkg::OP_HOST_FPR) counted++;
      end
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
